// ===== design/fmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmsp_pkg
// Types and character codes shared by the file mode spec parser.
// ----------------------------------------------------------------------------
package fmsp_pkg;

    localparam int MODE_W = 9;
    localparam int ACC_W  = 16;

    localparam logic [MODE_W-1:0] MODE_MAX = 9'o777;
    localparam logic [2:0]        WHO_ALL  = 3'b111;

    // Who letters
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    // Operators
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    // Permission letters and separator
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    // Octal digits are 0x30..0x37: upper five bits fixed
    localparam logic [4:0] DIGIT_HI = 5'b00110;

    typedef enum logic {
        PHASE_WHO,
        PHASE_PERM
    } phase_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_SET
    } op_t;

    // Clause in progress, handed to the clause unit
    typedef struct packed {
        logic [2:0] who;
        op_t        op;
        logic [2:0] perm;
    } clause_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              error;
        logic              was_octal;
    } result_t;

endpackage

// ===== design/fmsp_clause_apply.sv =====
// ----------------------------------------------------------------------------
// fmsp_clause_apply
// Checks a finished symbolic clause and applies it to the working mode.
// ----------------------------------------------------------------------------
module fmsp_clause_apply
    import fmsp_pkg::*;
(
    input  clause_t           clause,
    input  logic [MODE_W-1:0] mode_in,
    output logic              clause_ok,
    output logic [MODE_W-1:0] mode_out
);

    // An empty permission list is only legal with '='
    assign clause_ok = (clause.perm != 3'b000) || (clause.op == OP_SET);

    // One 3-bit field per class: other in [2:0], group [5:3], user [8:6]
    always_comb begin
        mode_out = mode_in;
        for (int k = 0; k < 3; k++) begin
            if (clause.who[k]) begin
                case (clause.op)
                    OP_ADD:  mode_out[k*3 +: 3] = mode_in[k*3 +: 3] | clause.perm;
                    OP_SUB:  mode_out[k*3 +: 3] = mode_in[k*3 +: 3] & ~clause.perm;
                    default: mode_out[k*3 +: 3] = clause.perm;
                endcase
            end
        end
    end

endmodule

// ===== design/file_mode_spec_parser_top.sv =====
// ----------------------------------------------------------------------------
// file_mode_spec_parser_top
// Parses a permission string, one character per item, as octal or symbolic.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless a waiting result stalls input; parser registers update on each accepted item.
// The result is registered and is valid in the cycle after the terminator item is accepted.
// A waiting result stalls input only until m_ready takes it (output register).
// Reset (aresetn low, synchronous): start mode 0, parser cleared, no result.
module file_mode_spec_parser_top
    import fmsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  item_t             s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output result_t           m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] cfg_data
);

    logic [MODE_W-1:0] start_mode_reg;
    logic [ACC_W-1:0]  accum_reg;
    logic              all_octal_reg;
    logic              seen_reg;
    logic [MODE_W-1:0] work_mode_reg;
    phase_t            phase_reg;
    clause_t           clause_reg;
    logic              failed_reg;
    logic              m_valid_reg;
    result_t           m_data_reg;

    logic              s_fire;
    logic              clause_ok;
    logic [MODE_W-1:0] applied_mode;
    logic [7:0]        c;
    logic              is_digit;
    result_t           result_next;
    logic              sym_err;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign c         = s_data.ch;
    assign is_digit  = (c[7:3] == DIGIT_HI);

    fmsp_clause_apply u_clause (
        .clause    (clause_reg),
        .mode_in   (work_mode_reg),
        .clause_ok (clause_ok),
        .mode_out  (applied_mode)
    );

    // Final result for a terminator item
    always_comb begin
        result_next = '0;
        sym_err     = 1'b0;
        if (!seen_reg) begin
            result_next.error = 1'b1;
        end else if (all_octal_reg) begin
            result_next.was_octal = 1'b1;
            if (accum_reg > ACC_W'(MODE_MAX)) begin
                result_next.error = 1'b1;
            end else begin
                result_next.mode = accum_reg[MODE_W-1:0];
            end
        end else begin
            if (failed_reg) begin
                sym_err = 1'b1;
            end else if (phase_reg == PHASE_PERM) begin
                sym_err = !clause_ok;
                result_next.mode = applied_mode;
            end else begin
                sym_err = (clause_reg.who != 3'b000);
                result_next.mode = work_mode_reg;
            end
            result_next.error = sym_err;
        end
        if (result_next.error) begin
            result_next.mode = start_mode_reg;
        end
    end

    // Parser state, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mode_reg <= '0;
            accum_reg      <= '0;
            all_octal_reg  <= 1'b1;
            seen_reg       <= 1'b0;
            work_mode_reg  <= '0;
            phase_reg      <= PHASE_WHO;
            clause_reg     <= '{who: 3'b000, op: OP_ADD, perm: 3'b000};
            failed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Output register: load on a terminator, drain when taken
            if (s_fire && s_data.end_of_string) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Configuration write; reloads working mode before the first character
            if (cfg_valid) begin
                start_mode_reg <= cfg_data;
                if (!seen_reg && !(s_fire && s_data.end_of_string)) begin
                    work_mode_reg <= cfg_data;
                end
            end

            if (s_fire && s_data.end_of_string) begin
                // Terminator: emit result, clear per-string state
                m_data_reg    <= result_next;
                accum_reg     <= '0;
                all_octal_reg <= 1'b1;
                seen_reg      <= 1'b0;
                work_mode_reg <= cfg_valid ? cfg_data : start_mode_reg;
                phase_reg     <= PHASE_WHO;
                clause_reg    <= '{who: 3'b000, op: OP_ADD, perm: 3'b000};
                failed_reg    <= 1'b0;
            end else if (s_fire) begin
                seen_reg <= 1'b1;

                // Octal accumulator wraps at its width
                if (is_digit) begin
                    accum_reg <= {accum_reg[ACC_W-4:0], c[2:0]};
                end else begin
                    all_octal_reg <= 1'b0;
                end

                // Symbolic grammar
                if (!failed_reg) begin
                    unique case (phase_reg)
                        PHASE_WHO: begin
                            case (c)
                                CH_U: clause_reg.who <= clause_reg.who | 3'b100;
                                CH_G: clause_reg.who <= clause_reg.who | 3'b010;
                                CH_O: clause_reg.who <= clause_reg.who | 3'b001;
                                CH_A: clause_reg.who <= WHO_ALL;
                                CH_PLUS, CH_MINUS, CH_EQ: begin
                                    clause_reg.op <= (c == CH_PLUS)  ? OP_ADD :
                                                     (c == CH_MINUS) ? OP_SUB : OP_SET;
                                    if (clause_reg.who == 3'b000) begin
                                        clause_reg.who <= WHO_ALL;
                                    end
                                    phase_reg <= PHASE_PERM;
                                end
                                default: failed_reg <= 1'b1;
                            endcase
                        end
                        PHASE_PERM: begin
                            case (c)
                                CH_R: clause_reg.perm <= clause_reg.perm | 3'b100;
                                CH_W: clause_reg.perm <= clause_reg.perm | 3'b010;
                                CH_X: clause_reg.perm <= clause_reg.perm | 3'b001;
                                CH_COMMA: begin
                                    if (!clause_ok) begin
                                        failed_reg <= 1'b1;
                                    end else begin
                                        work_mode_reg <= applied_mode;
                                        phase_reg     <= PHASE_WHO;
                                        clause_reg    <= '{who: 3'b000, op: OP_ADD,
                                                           perm: 3'b000};
                                    end
                                end
                                default: failed_reg <= 1'b1;
                            endcase
                        end
                        default: failed_reg <= 1'b1;
                    endcase
                end
            end
        end
    end

    // A result appears only after a terminator item was taken
    a_result_from_term: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_fire && s_data.end_of_string))
        else $error("result without terminator item");

    // A terminator always loads the output register
    a_term_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_string) |=> m_valid_reg)
        else $error("terminator item lost");

    // A terminator clears the per-string state
    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_string) |=>
            (!seen_reg && all_octal_reg && !failed_reg && phase_reg == PHASE_WHO))
        else $error("string state not cleared");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the file mode spec parser. Mode strings, octal and
// symbolic, go in one character per item with random bursts and gaps, while
// the result side stalls on its own pattern. An item-level model of the
// parser predicts each terminator's result, and every result item is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import fmsp_pkg::*;

    localparam int RAND_ITEMS  = 1950;
    localparam int PHASES      = 8;
    localparam int SETTLE      = 3;
    localparam int LIMIT       = 200000;
    localparam int MAX_REPORTS = 40;
    localparam int GRAMMAR_N   = 19;
    localparam int DIR_N       = 11;

    typedef enum {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_RARE
    } rdy_mode_t;

    // One directed string: optional register write before it and before its
    // terminator, and a typed result where one is pinned
    typedef struct packed {
        bit                pre;
        logic [MODE_W-1:0] pre_val;
        bit                mid;
        logic [MODE_W-1:0] mid_val;
        bit                pin;
        result_t           want;
    } dir_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    item_t             s_data;
    logic              m_valid;
    logic              m_ready;
    result_t           m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_data;

    // Pinned result travels with the terminator item until it is accepted
    bit                pin_on;
    result_t           pin_res;

    int                cycle_count;
    int                items_sent;
    int                fails;
    int                burst_left;
    bit                no_gaps;
    rdy_mode_t         rdy_mode;

    logic [7:0]        text_q [$];
    int                text_len;
    result_t           pending_modes [$];

    // Parser model state
    logic [MODE_W-1:0] pm_start;
    logic [ACC_W-1:0]  pm_accum;
    bit                pm_all_digits;
    bit                pm_seen;
    logic [MODE_W-1:0] pm_work;
    phase_t            pm_phase;
    logic [2:0]        pm_who;
    op_t               pm_op;
    logic [2:0]        pm_perm;
    bit                pm_failed;

    string dir_text [DIR_N] = '{
        "", "777", "1000", "200000", "+x", "u", "o=", "-w,", "=q", "\377", "=r"
    };

    dir_row_t dir_rows [DIR_N] = '{
        // empty string right after reset
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b1, {9'o000, 1'b1, 1'b0}},
        // largest octal value
        '{1'b1, 9'o777, 1'b0, 9'o000, 1'b1, {9'o777, 1'b0, 1'b1}},
        // octal above the mode range
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b1, {9'o777, 1'b1, 1'b1}},
        // accumulator wraps at 16 bits
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b0, '0},
        // no who letters
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b0, '0},
        // who letter with no operator
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b1, {9'o777, 1'b1, 1'b0}},
        // set with empty permission list
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b0, '0},
        // trailing comma
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b0, '0},
        // stray character among the permissions
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b1, {9'o777, 1'b1, 1'b0}},
        // byte above 127
        '{1'b0, 9'o000, 1'b0, 9'o000, 1'b1, {9'o777, 1'b1, 1'b0}},
        // start mode rewritten in the middle of a string
        '{1'b1, 9'o000, 1'b1, 9'o750, 1'b0, '0}
    };

    file_mode_spec_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Character set of the symbolic grammar, then the octal digits
    function automatic logic [7:0] grammar_char(input int idx);
        case (idx)
            0:       return CH_U;
            1:       return CH_G;
            2:       return CH_O;
            3:       return CH_A;
            4:       return CH_PLUS;
            5:       return CH_MINUS;
            6:       return CH_EQ;
            7:       return CH_R;
            8:       return CH_W;
            9:       return CH_X;
            10:      return CH_COMMA;
            default: return {DIGIT_HI, 3'(idx - 11)};
        endcase
    endfunction

    function automatic void clear_string();
        pm_accum      = '0;
        pm_all_digits = 1'b1;
        pm_seen       = 1'b0;
        pm_work       = pm_start;
        pm_phase      = PHASE_WHO;
        pm_who        = '0;
        pm_op         = OP_ADD;
        pm_perm       = '0;
        pm_failed     = 1'b0;
    endfunction

    // Apply the clause in progress to the working mode
    function automatic void close_clause();
        logic [MODE_W-1:0] bits;
        logic [MODE_W-1:0] field;
        int                shift;
        if (pm_perm == 3'b000 && pm_op != OP_SET) begin
            pm_failed = 1'b1;
            return;
        end
        for (int slot = 0; slot < 3; slot++) begin
            shift = (2 - slot) * 3;
            bits  = {6'b0, pm_perm} << shift;
            field = 9'o7 << shift;
            if (pm_who[2 - slot]) begin
                case (pm_op)
                    OP_ADD:  pm_work = pm_work | bits;
                    OP_SUB:  pm_work = pm_work & ~bits;
                    default: pm_work = (pm_work & ~field) | bits;
                endcase
            end
        end
        pm_phase = PHASE_WHO;
        pm_who   = '0;
        pm_perm  = '0;
        pm_op    = OP_ADD;
    endfunction

    // Advance the model by one item; returns 1 with the result on a terminator
    function automatic bit parse_item(input item_t it, output result_t res);
        logic [7:0] c;
        c   = it.ch;
        res = '0;
        if (!it.end_of_string) begin
            pm_seen = 1'b1;
            if (c[7:3] == DIGIT_HI)
                pm_accum = {pm_accum[ACC_W-4:0], c[2:0]};
            else
                pm_all_digits = 1'b0;
            if (!pm_failed) begin
                if (pm_phase == PHASE_WHO) begin
                    case (c)
                        CH_U: pm_who = pm_who | 3'b100;
                        CH_G: pm_who = pm_who | 3'b010;
                        CH_O: pm_who = pm_who | 3'b001;
                        CH_A: pm_who = WHO_ALL;
                        CH_PLUS, CH_MINUS, CH_EQ: begin
                            pm_op = (c == CH_PLUS) ? OP_ADD :
                                    (c == CH_MINUS) ? OP_SUB : OP_SET;
                            if (pm_who == 3'b000)
                                pm_who = WHO_ALL;
                            pm_phase = PHASE_PERM;
                        end
                        default: pm_failed = 1'b1;
                    endcase
                end else begin
                    case (c)
                        CH_R:     pm_perm = pm_perm | 3'b100;
                        CH_W:     pm_perm = pm_perm | 3'b010;
                        CH_X:     pm_perm = pm_perm | 3'b001;
                        CH_COMMA: close_clause();
                        default:  pm_failed = 1'b1;
                    endcase
                end
            end
            return 1'b0;
        end

        if (!pm_seen) begin
            res.mode  = pm_start;
            res.error = 1'b1;
        end else if (pm_all_digits) begin
            res.was_octal = 1'b1;
            if (pm_accum > MODE_MAX) begin
                res.mode  = pm_start;
                res.error = 1'b1;
            end else begin
                res.mode = pm_accum[MODE_W-1:0];
            end
        end else begin
            // close the last clause; who letters left hanging mean no operator
            if (!pm_failed) begin
                if (pm_phase == PHASE_PERM)
                    close_clause();
                else if (pm_who != 3'b000)
                    pm_failed = 1'b1;
            end
            if (pm_failed) begin
                res.mode  = pm_start;
                res.error = 1'b1;
            end else begin
                res.mode = pm_work;
            end
        end
        clear_string();
        return 1'b1;
    endfunction

    // Drive one item, with a random gap at the start of each burst unless no_gaps is set
    task automatic send_item(input item_t it, input bit pin, input result_t pres);
        int gap;
        if (burst_left == 0) begin
            burst_left = no_gaps ? 64 : $urandom_range(1, 12);
            gap        = no_gaps ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        pin_on  <= pin;
        pin_res <= pres;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Wait until every predicted result has come out
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_modes.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [MODE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send the first text_len characters of text_q, an optional start mode write, then a terminator with a random ch
    task automatic send_text(input bit mid, input logic [MODE_W-1:0] mid_val,
                             input bit pin, input result_t pres);
        for (int i = 0; i < text_len; i++)
            send_item({text_q[i], 1'b0}, 1'b0, '0);
        if (mid) begin
            settle();
            write_cfg(mid_val);
        end
        send_item({8'($urandom_range(0, 255)), 1'b1}, pin, pres);
    endtask

    // Cycle counter and run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("file_mode_spec_parser_top regression: fail");
            $finish;
        end
    end

    // Result side readiness
    always @(negedge aclk) begin
        case (rdy_mode)
            RDY_ALWAYS:   m_ready <= 1'b1;
            RDY_RANDOM:   m_ready <= ($urandom_range(0, 9) < 7);
            RDY_PERIODIC: m_ready <= ((cycle_count % 23) < 15);
            default:      m_ready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // Check results, track register writes, predict accepted items
    always @(posedge aclk) begin : scoreboard
        result_t want;
        result_t pred;
        bit      has;
        if (!aresetn) begin
            pm_start = '0;
            clear_string();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_modes.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, actual mode %o error %b was_octal %b",
                                 $time, m_data.mode, m_data.error, m_data.was_octal);
                end else begin
                    want = pending_modes.pop_front();
                    if (m_data !== want) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: result mismatch: expected mode %o error %b was_octal %b, actual mode %o error %b was_octal %b",
                                     $time, want.mode, want.error, want.was_octal,
                                     m_data.mode, m_data.error, m_data.was_octal);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                pm_start = cfg_data;
                if (!pm_seen)
                    pm_work = cfg_data;
            end
            if (s_valid && s_ready) begin
                has = parse_item(s_data, pred);
                if (has)
                    pending_modes.push_back(pin_on ? pin_res : pred);
            end
        end
    end

    initial begin : stimulus
        int               target;
        int               kind;
        int               nclause;
        int               nperm;
        int               pos;
        logic [7:0]       c_op;
        logic [MODE_W-1:0] cfg_val;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        pin_on      = 1'b0;
        pin_res     = '0;
        cycle_count = 0;
        items_sent  = 0;
        fails       = 0;
        burst_left  = 0;
        no_gaps     = 1'b0;
        rdy_mode    = RDY_ALWAYS;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed strings
        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].pre) begin
                settle();
                write_cfg(dir_rows[r].pre_val);
            end
            text_q.delete();
            for (int i = 0; i < dir_text[r].len(); i++)
                text_q.push_back(dir_text[r][i]);
            text_len = text_q.size();
            send_text(dir_rows[r].mid, dir_rows[r].mid_val, dir_rows[r].pin,
                      dir_rows[r].want);
        end

        // Random strings, one start mode and handshake pattern per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       cfg_val = '0;
                1:       cfg_val = MODE_MAX;
                default: cfg_val = MODE_W'($urandom_range(0, 511));
            endcase
            write_cfg(cfg_val);
            rdy_mode   = rdy_mode_t'(ph % 4);
            no_gaps    = (ph % 3 == 2);
            burst_left = 0;
            target     = items_sent + RAND_ITEMS / PHASES;

            while (items_sent < target) begin
                kind = $urandom_range(0, 9);
                text_q.delete();
                if (kind < 5 || kind == 7 || kind == 8) begin
                    // well-formed symbolic clauses
                    nclause = $urandom_range(1, 3);
                    for (int k = 0; k < nclause; k++) begin
                        if (k > 0)
                            text_q.push_back(CH_COMMA);
                        repeat ($urandom_range(0, 3))
                            text_q.push_back(grammar_char($urandom_range(0, 3)));
                        c_op = grammar_char($urandom_range(4, 6));
                        text_q.push_back(c_op);
                        nperm = $urandom_range((c_op == CH_EQ) ? 0 : 1, 3);
                        repeat (nperm)
                            text_q.push_back(grammar_char($urandom_range(7, 9)));
                    end
                    if ($urandom_range(0, 7) == 0)
                        text_q.push_back(CH_COMMA);
                    text_len = text_q.size();
                    // broken: one character replaced, or the string cut short
                    if (kind >= 7) begin
                        pos = $urandom_range(0, text_q.size() - 1);
                        case ($urandom_range(0, 2))
                            0:       text_q[pos] = 8'($urandom_range(0, 255));
                            1:       text_len = pos + 1;
                            default: text_q[pos] = grammar_char($urandom_range(0, GRAMMAR_N - 1));
                        endcase
                    end
                end else if (kind < 7) begin
                    // octal digits, mostly short, some long enough to wrap
                    nperm = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7)
                                                        : $urandom_range(1, 3);
                    repeat (nperm)
                        text_q.push_back({DIGIT_HI, 3'($urandom_range(0, 7))});
                    text_len = text_q.size();
                end else begin
                    // raw bytes, possibly none
                    repeat ($urandom_range(0, 5))
                        text_q.push_back(8'($urandom_range(0, 255)));
                    text_len = text_q.size();
                end
                send_text(1'b0, '0, 1'b0, '0);
            end
        end

        settle();
        if (fails == 0)
            $display("file_mode_spec_parser_top regression: pass");
        else
            $display("file_mode_spec_parser_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/fmsp_pkg.sv
design/fmsp_clause_apply.sv
design/file_mode_spec_parser_top.sv
bench/tb_top.sv
